// ===== hdl/tpva_pkg.sv =====
// shared types, constants and helper functions for the vertex angle pipeline
`default_nettype none
package tpva_pkg;

  localparam int COORD_WIDTH     = 16;
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int ANGLE_W         = 16;
  localparam int DIFF_W          = COORD_WIDTH + 1;
  localparam int NORM_TOP        = 29;
  localparam int MAG_W           = NORM_TOP + 1;
  localparam int VEC_W           = MAG_W + 1;
  localparam int PROD_W          = 2 * VEC_W;
  localparam int DC_W            = 64;
  localparam int POS_W           = 6;
  localparam int CORDIC_STEPS    = 30;
  localparam int CZ_W            = 34;

  localparam logic signed [CZ_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CZ_W-1:0] RND_ADD     = 34'sd1 <<< (29 - ANGLE_FRAC_BITS);

  localparam longint PI_ROUND   = (64'sd3373259426 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS)))
                                  >>> (30 - ANGLE_FRAC_BITS);
  localparam longint HALF_ROUND = (64'sd1686629713 + (64'sd1 <<< (29 - ANGLE_FRAC_BITS)))
                                  >>> (30 - ANGLE_FRAC_BITS);
  localparam logic [ANGLE_W-1:0] ANGLE_PI_Q   = (PI_ROUND > 65535) ? 16'hFFFF
                                                : ANGLE_W'(PI_ROUND);
  localparam logic [ANGLE_W-1:0] ANGLE_HALF_Q = (HALF_ROUND > 65535) ? 16'hFFFF
                                                : ANGLE_W'(HALF_ROUND);

  typedef enum logic [2:0] {
    MODE_CORDIC = 3'd0,
    MODE_DEGEN  = 3'd1,
    MODE_SAME   = 3'd2,
    MODE_OPP    = 3'd3,
    MODE_PERP   = 3'd4
  } mode_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
  } in_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle_rad_q;
    logic               degenerate;
  } out_t;

  // position of the highest set bit, zero for zero
  function automatic logic [POS_W-1:0] msb_pos(input logic [DC_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < DC_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  // bring a magnitude whose top bit is at p to the top bit NORM_TOP
  function automatic logic [MAG_W-1:0] norm_mag(input logic [DC_W-1:0] m,
                                                input logic [POS_W-1:0] p);
    logic [DC_W-1:0] s;
    if (p >= POS_W'(NORM_TOP)) begin
      s = m >> (p - POS_W'(NORM_TOP));
    end else begin
      s = m << (POS_W'(NORM_TOP) - p);
    end
    return s[MAG_W-1:0];
  endfunction

  // arctangent of 2^-i in q30
  function automatic logic signed [CZ_W-1:0] atan_q30(input int i);
    logic signed [CZ_W-1:0] a;
    case (i)
      0:  a = 34'sd843314856;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043836;
      3:  a = 34'sd133525158;
      4:  a = 34'sd67021686;
      5:  a = 34'sd33543515;
      6:  a = 34'sd16775850;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194282;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048575;
      11: a = 34'sd524287;
      12: a = 34'sd262143;
      13: a = 34'sd131071;
      14: a = 34'sd65535;
      15: a = 34'sd32767;
      16: a = 34'sd16383;
      17: a = 34'sd8191;
      18: a = 34'sd4095;
      19: a = 34'sd2047;
      20: a = 34'sd1023;
      21: a = 34'sd511;
      22: a = 34'sd255;
      23: a = 34'sd127;
      24: a = 34'sd63;
      25: a = 34'sd31;
      26: a = 34'sd15;
      27: a = 34'sd7;
      28: a = 34'sd3;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/three_point_vertex_angle.sv =====
// vertex angle between two rays: normalize, dot and cross, cordic vectoring, round
`default_nettype none
// throughput: one transaction per cycle while out_stall is low; each stage has its own valid bit and
//   a stage loads whenever it is empty or the stage after it moves on
// reset: synchronous active-low rst_n clears every stage valid bit; data
//   registers are not reset
module three_point_vertex_angle (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tpva_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output tpva_pkg::out_t   out_data
);
  import tpva_pkg::*;

  // stage map: 0 input, 1 differences, 2 vector normalize, 3 products,
  // 4 dot and cross, 5 leading one, 6 pair normalize and pre-rotation,
  // 7..36 cordic steps, 37 output register
  localparam int NST   = 38;
  localparam int CBASE = 6;

  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  mode_t          mode_r [1:NST-2];

  // stage registers
  in_t                           in_r;
  logic signed [DIFF_W-1:0]      ax1_r, ay1_r, bx1_r, by1_r;
  logic signed [VEC_W-1:0]       ax2_r, ay2_r, bx2_r, by2_r;
  logic signed [PROD_W-1:0]      pxx3_r, pyy3_r, pxy3_r, pyx3_r;
  logic signed [DC_W-1:0]        d4_r;
  logic [DC_W-1:0]               c4_r;
  logic [DC_W-1:0]               dm5_r, c5_r;
  logic                          dneg5_r;
  logic [POS_W-1:0]              p5_r;
  logic signed [CZ_W-1:0]        cx_r [0:CORDIC_STEPS];
  logic signed [CZ_W-1:0]        cy_r [0:CORDIC_STEPS];
  logic signed [CZ_W-1:0]        cz_r [0:CORDIC_STEPS];
  out_t                          out_r;

  // next values
  logic signed [DIFF_W-1:0]      ax_nxt, ay_nxt, bx_nxt, by_nxt;
  mode_t                         mode1_nxt, mode4_nxt;
  logic [DIFF_W-1:0]             max_m, may_m, mbx_m, mby_m;
  logic [POS_W-1:0]              pa, pb;
  logic [MAG_W-1:0]              nax, nay, nbx, nby;
  logic signed [VEC_W-1:0]       ax2_nxt, ay2_nxt, bx2_nxt, by2_nxt;
  logic signed [DC_W-1:0]        d4_nxt, cr4;
  logic [DC_W-1:0]               c4_nxt, dm5_nxt;
  logic [MAG_W-1:0]              nd6, nc6;
  logic signed [CZ_W-1:0]        x6_nxt, y6_nxt, z6_nxt;
  logic signed [CZ_W-1:0]        cx_nxt [1:CORDIC_STEPS];
  logic signed [CZ_W-1:0]        cy_nxt [1:CORDIC_STEPS];
  logic signed [CZ_W-1:0]        cz_nxt [1:CORDIC_STEPS];
  logic signed [CZ_W-1:0]        zc;
  logic [CZ_W-1:0]               rnd;
  out_t                          out_nxt;

  // a stage loads when it is empty or its successor loads too
  always_comb begin
    en[NST-1] = !vld_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NST-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // stage 1: ray vectors and coincidence check
  always_comb begin
    ax_nxt = DIFF_W'(in_r.first_x)  - DIFF_W'(in_r.vertex_x);
    ay_nxt = DIFF_W'(in_r.first_y)  - DIFF_W'(in_r.vertex_y);
    bx_nxt = DIFF_W'(in_r.second_x) - DIFF_W'(in_r.vertex_x);
    by_nxt = DIFF_W'(in_r.second_y) - DIFF_W'(in_r.vertex_y);
    if ((ax_nxt == '0 && ay_nxt == '0) || (bx_nxt == '0 && by_nxt == '0)) begin
      mode1_nxt = MODE_DEGEN;
    end else begin
      mode1_nxt = MODE_CORDIC;
    end
  end

  // stage 2: scale each vector so its larger magnitude has its top bit at 29
  always_comb begin
    max_m = ax1_r[DIFF_W-1] ? DIFF_W'(-ax1_r) : DIFF_W'(ax1_r);
    may_m = ay1_r[DIFF_W-1] ? DIFF_W'(-ay1_r) : DIFF_W'(ay1_r);
    mbx_m = bx1_r[DIFF_W-1] ? DIFF_W'(-bx1_r) : DIFF_W'(bx1_r);
    mby_m = by1_r[DIFF_W-1] ? DIFF_W'(-by1_r) : DIFF_W'(by1_r);
    pa    = msb_pos(DC_W'(max_m | may_m));
    pb    = msb_pos(DC_W'(mbx_m | mby_m));
    nax   = norm_mag(DC_W'(max_m), pa);
    nay   = norm_mag(DC_W'(may_m), pa);
    nbx   = norm_mag(DC_W'(mbx_m), pb);
    nby   = norm_mag(DC_W'(mby_m), pb);
    ax2_nxt = ax1_r[DIFF_W-1] ? -$signed({1'b0, nax}) : $signed({1'b0, nax});
    ay2_nxt = ay1_r[DIFF_W-1] ? -$signed({1'b0, nay}) : $signed({1'b0, nay});
    bx2_nxt = bx1_r[DIFF_W-1] ? -$signed({1'b0, nbx}) : $signed({1'b0, nbx});
    by2_nxt = by1_r[DIFF_W-1] ? -$signed({1'b0, nby}) : $signed({1'b0, nby});
  end

  // stage 4: dot and absolute cross, exact special cases
  always_comb begin
    d4_nxt = DC_W'(pxx3_r) + DC_W'(pyy3_r);
    cr4    = DC_W'(pxy3_r) - DC_W'(pyx3_r);
    c4_nxt = cr4[DC_W-1] ? DC_W'(-cr4) : DC_W'(cr4);
    mode4_nxt = mode_r[3];
    if (mode_r[3] == MODE_CORDIC) begin
      if (c4_nxt == '0) begin
        mode4_nxt = (d4_nxt > 0) ? MODE_SAME : MODE_OPP;
      end else if (d4_nxt == '0) begin
        mode4_nxt = MODE_PERP;
      end
    end
  end

  assign dm5_nxt = d4_r[DC_W-1] ? DC_W'(-d4_r) : DC_W'(d4_r);

  // stage 6: normalize the (dot, cross) pair, turn by -pi/2 for an obtuse angle
  always_comb begin
    nd6 = norm_mag(dm5_r, p5_r);
    nc6 = norm_mag(c5_r, p5_r);
    if (dneg5_r) begin
      x6_nxt = CZ_W'(nc6);
      y6_nxt = CZ_W'(nd6);
      z6_nxt = HALF_PI_Q30;
    end else begin
      x6_nxt = CZ_W'(nd6);
      y6_nxt = CZ_W'(nc6);
      z6_nxt = '0;
    end
  end

  // cordic vectoring, one micro-rotation per stage
  always_comb begin
    for (int j = 1; j <= CORDIC_STEPS; j++) begin
      if (!cy_r[j-1][CZ_W-1]) begin
        cx_nxt[j] = cx_r[j-1] + (cy_r[j-1] >>> (j - 1));
        cy_nxt[j] = cy_r[j-1] - (cx_r[j-1] >>> (j - 1));
        cz_nxt[j] = cz_r[j-1] + atan_q30(j - 1);
      end else begin
        cx_nxt[j] = cx_r[j-1] - (cy_r[j-1] >>> (j - 1));
        cy_nxt[j] = cy_r[j-1] + (cx_r[j-1] >>> (j - 1));
        cz_nxt[j] = cz_r[j-1] - atan_q30(j - 1);
      end
    end
  end

  // output: clamp to 0..pi, round half up, saturate, or take a special value
  always_comb begin
    if (cz_r[CORDIC_STEPS][CZ_W-1]) begin
      zc = '0;
    end else if (cz_r[CORDIC_STEPS] > PI_Q30) begin
      zc = PI_Q30;
    end else begin
      zc = cz_r[CORDIC_STEPS];
    end
    rnd = CZ_W'(zc + RND_ADD) >> (30 - ANGLE_FRAC_BITS);
    out_nxt.degenerate = 1'b0;
    case (mode_r[NST-2])
      MODE_DEGEN: begin
        out_nxt.angle_rad_q = '0;
        out_nxt.degenerate  = 1'b1;
      end
      MODE_SAME:  out_nxt.angle_rad_q = '0;
      MODE_OPP:   out_nxt.angle_rad_q = ANGLE_PI_Q;
      MODE_PERP:  out_nxt.angle_rad_q = ANGLE_HALF_Q;
      default: begin
        out_nxt.angle_rad_q = (rnd > CZ_W'(16'hFFFF)) ? 16'hFFFF : rnd[ANGLE_W-1:0];
      end
    endcase
  end

  // data registers, loaded by stage enable
  always_ff @(posedge clk) begin
    if (en[0]) in_r <= in_data;
    if (en[1]) begin
      ax1_r <= ax_nxt;
      ay1_r <= ay_nxt;
      bx1_r <= bx_nxt;
      by1_r <= by_nxt;
      mode_r[1] <= mode1_nxt;
    end
    if (en[2]) begin
      ax2_r <= ax2_nxt;
      ay2_r <= ay2_nxt;
      bx2_r <= bx2_nxt;
      by2_r <= by2_nxt;
    end
    if (en[3]) begin
      pxx3_r <= ax2_r * bx2_r;
      pyy3_r <= ay2_r * by2_r;
      pxy3_r <= ax2_r * by2_r;
      pyx3_r <= ay2_r * bx2_r;
    end
    if (en[4]) begin
      d4_r <= d4_nxt;
      c4_r <= c4_nxt;
      mode_r[4] <= mode4_nxt;
    end
    if (en[5]) begin
      dm5_r   <= dm5_nxt;
      c5_r    <= c4_r;
      dneg5_r <= d4_r[DC_W-1];
      p5_r    <= msb_pos(dm5_nxt | c4_r);
    end
    if (en[CBASE]) begin
      cx_r[0] <= x6_nxt;
      cy_r[0] <= y6_nxt;
      cz_r[0] <= z6_nxt;
    end
    for (int j = 1; j <= CORDIC_STEPS; j++) begin
      if (en[CBASE+j]) begin
        cx_r[j] <= cx_nxt[j];
        cy_r[j] <= cy_nxt[j];
        cz_r[j] <= cz_nxt[j];
      end
    end
    for (int k = 2; k < NST - 1; k++) begin
      if (k != 4 && en[k]) mode_r[k] <= mode_r[k-1];
    end
    if (en[NST-1]) out_r <= out_nxt;
  end

endmodule
`default_nettype wire
